[rtl/core/floppy_sector_record_parser_assert.svh]
// assertion macros for the sector record parser
`ifndef FLOPPY_SECTOR_RECORD_PARSER_ASSERT_SVH
`define FLOPPY_SECTOR_RECORD_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF

`define FSRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsrp assertion failed");

`define FSRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsrp assertion failed");

`else

`define FSRP_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define FSRP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/fsrp_pkg.sv]
package fsrp_pkg;

    localparam int unsigned MAX_SIZE_CODE_DEF = 7;
    localparam int unsigned BLOCK_BASE = 128;

    localparam logic [7:0] SYNC_BYTE    = 8'ha1;
    localparam logic [7:0] MARK_ID      = 8'hfe;
    localparam logic [7:0] MARK_DATA_LO = 8'hf8;
    localparam logic [7:0] MARK_DATA_HI = 8'hfb;

    localparam logic [15:0] CRC_INIT = 16'hffff;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [1:0] KIND_HEADER    = 2'd0;
    localparam logic [1:0] KIND_DATA_BYTE = 2'd1;
    localparam logic [1:0] KIND_DATA_STAT = 2'd2;

    localparam logic [2:0] ST_HDR_OK      = 3'd0;
    localparam logic [2:0] ST_HDR_CRC_BAD = 3'd1;
    localparam logic [2:0] ST_HDR_IGNORED = 3'd2;
    localparam logic [2:0] ST_DATA_OK     = 3'd3;
    localparam logic [2:0] ST_DATA_BAD    = 3'd4;

    localparam logic [2:0] REG_PHYS_TRACK   = 3'd0;
    localparam logic [2:0] REG_PHYS_SIDE    = 3'd1;
    localparam logic [2:0] REG_IGNORE_TRACK = 3'd2;
    localparam logic [2:0] REG_IGNORE_SIDE  = 3'd3;
    localparam logic [2:0] REG_INVERT_SIDE  = 3'd4;
    localparam logic [2:0] REG_SKIP_ENABLE  = 3'd5;
    localparam logic [2:0] REG_SKIP_NUMBER  = 3'd6;

    typedef struct packed {
        logic [7:0] phys_track;
        logic       phys_side;
        logic       track_from_phys;
        logic       side_from_phys;
        logic       side_flip;
        logic       skip_sector_enable;
        logic [7:0] skip_sector_number;
    } cfg_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] payload_byte;
        logic [7:0] log_track;
        logic [7:0] log_side;
        logic [7:0] log_sector;
        logic [2:0] size_code;
        logic [2:0] status;
        logic       last;
    } res_t;

endpackage

[rtl/core/fsrp_cfg.sv]
module fsrp_cfg
    import fsrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PHYS_TRACK:   cfg_next.phys_track = cfg_data;
                REG_PHYS_SIDE:    cfg_next.phys_side = cfg_data[0];
                REG_IGNORE_TRACK: cfg_next.track_from_phys = cfg_data[0];
                REG_IGNORE_SIDE:  cfg_next.side_from_phys = cfg_data[0];
                REG_INVERT_SIDE:  cfg_next.side_flip = cfg_data[0];
                REG_SKIP_ENABLE:  cfg_next.skip_sector_enable = cfg_data[0];
                REG_SKIP_NUMBER:  cfg_next.skip_sector_number = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/core/fsrp_parser.sv]
module fsrp_parser
    import fsrp_pkg::*;
#(
    parameter int unsigned MAX_SIZE_CODE = MAX_SIZE_CODE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       record_start,
    input  logic [7:0] disk_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output res_t       res
);

    localparam int unsigned CNT_W = $clog2((BLOCK_BASE << MAX_SIZE_CODE) + 2);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_SYNC = 3'd1;
    localparam logic [2:0] PH_MARK = 3'd2;
    localparam logic [2:0] PH_HDR  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    logic [2:0]       phase_reg,    phase_next;
    logic [CNT_W-1:0] count_reg,    count_next;
    logic [15:0]      crc_reg,      crc_next;
    logic [1:0]       sync_reg,     sync_next;
    logic [7:0]       track_reg,    track_next;
    logic [7:0]       side_reg,     side_next;
    logic [7:0]       sector_reg,   sector_next;
    logic [2:0]       size_reg,     size_next;
    logic             seen_reg,     seen_next;
    logic [7:0]       crc_hi_reg,   crc_hi_next;

    logic [15:0]      crc_upd;
    logic [15:0]      crc_want;
    logic [CNT_W-1:0] data_len;
    logic [2:0]       size_sat;
    logic [2:0]       mark_phase;
    logic [2:0]       hdr_status;

    assign crc_upd  = crc_update(record_start ? CRC_INIT : crc_reg, disk_byte);
    assign crc_want = {crc_hi_reg, disk_byte};
    assign data_len = CNT_W'(BLOCK_BASE) << size_reg;
    assign size_sat = (disk_byte > 8'(MAX_SIZE_CODE)) ? 3'(MAX_SIZE_CODE) : disk_byte[2:0];

    always_comb
    begin
        if (disk_byte == MARK_ID)
        begin
            mark_phase = PH_HDR;
        end
        else if ((disk_byte inside {[MARK_DATA_LO:MARK_DATA_HI]}) && seen_reg)
        begin
            mark_phase = PH_DATA;
        end
        else
        begin
            mark_phase = PH_IDLE;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        sync_next   = sync_reg;
        track_next  = track_reg;
        side_next   = side_reg;
        sector_next = sector_reg;
        size_next   = size_reg;
        seen_next   = seen_reg;
        crc_hi_next = crc_hi_reg;
        res_valid   = 1'b0;
        res         = '0;
        hdr_status  = ST_HDR_OK;

        if (in_valid)
        begin
            if (record_start)
            begin
                crc_next = crc_upd;
                if (disk_byte == SYNC_BYTE)
                begin
                    phase_next = PH_SYNC;
                    sync_next  = 2'd2;
                end
                else
                begin
                    count_next = '0;
                    phase_next = mark_phase;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_SYNC:
                    begin
                        crc_next  = crc_upd;
                        sync_next = sync_reg - 2'd1;
                        if (sync_reg == 2'd1)
                        begin
                            phase_next = PH_MARK;
                        end
                    end
                    PH_MARK:
                    begin
                        crc_next   = crc_upd;
                        count_next = '0;
                        phase_next = mark_phase;
                    end
                    PH_HDR:
                    begin
                        if (count_reg < CNT_W'(4))
                        begin
                            crc_next   = crc_upd;
                            count_next = count_reg + CNT_W'(1);
                            case (count_reg[1:0])
                                2'd0:    track_next = disk_byte;
                                2'd1:    side_next = disk_byte;
                                2'd2:    sector_next = disk_byte;
                                default: size_next = size_sat;
                            endcase
                        end
                        else if (count_reg == CNT_W'(4))
                        begin
                            crc_hi_next = disk_byte;
                            count_next  = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            hdr_status = (crc_want == crc_reg) ? ST_HDR_OK : ST_HDR_CRC_BAD;
                            side_next  = (cfg.side_from_phys ? {7'd0, cfg.phys_side}
                                                             : side_reg)
                                         ^ {7'd0, cfg.side_flip};
                            if (cfg.track_from_phys)
                            begin
                                track_next = cfg.phys_track;
                            end
                            if (cfg.skip_sector_enable && (sector_reg == cfg.skip_sector_number))
                            begin
                                hdr_status = ST_HDR_IGNORED;
                            end
                            seen_next       = (hdr_status == ST_HDR_OK);
                            phase_next      = PH_IDLE;
                            count_next      = '0;
                            res_valid       = 1'b1;
                            res.result_kind = KIND_HEADER;
                            res.log_track   = track_next;
                            res.log_side    = side_next;
                            res.log_sector  = sector_reg;
                            res.size_code   = size_reg;
                            res.status      = hdr_status;
                            res.last        = 1'b1;
                        end
                    end
                    PH_DATA:
                    begin
                        res.log_track  = track_reg;
                        res.log_side   = side_reg;
                        res.log_sector = sector_reg;
                        res.size_code  = size_reg;
                        if (count_reg < data_len)
                        begin
                            crc_next         = crc_upd;
                            count_next       = count_reg + CNT_W'(1);
                            res_valid        = 1'b1;
                            res.result_kind  = KIND_DATA_BYTE;
                            res.payload_byte = disk_byte;
                        end
                        else if (count_reg == data_len)
                        begin
                            crc_hi_next = disk_byte;
                            count_next  = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            seen_next       = 1'b0;
                            phase_next      = PH_IDLE;
                            count_next      = '0;
                            res_valid       = 1'b1;
                            res.result_kind = KIND_DATA_STAT;
                            res.status      = (crc_want == crc_reg) ? ST_DATA_OK : ST_DATA_BAD;
                            res.last        = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            count_reg  <= '0;
            crc_reg    <= CRC_INIT;
            sync_reg   <= '0;
            track_reg  <= '0;
            side_reg   <= '0;
            sector_reg <= '0;
            size_reg   <= '0;
            seen_reg   <= 1'b0;
            crc_hi_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            sync_reg   <= sync_next;
            track_reg  <= track_next;
            side_reg   <= side_next;
            sector_reg <= sector_next;
            size_reg   <= size_next;
            seen_reg   <= seen_next;
            crc_hi_reg <= crc_hi_next;
        end
    end

endmodule

[rtl/core/fsrp_out_buf.sv]
module fsrp_out_buf
    import fsrp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  res_t in_res,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic main_valid_reg, main_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t main_reg,       main_next;
    res_t skid_reg,       skid_next;
    logic push;
    logic pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_next = in_res;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_next       = in_res;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = in_res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

[rtl/core/floppy_sector_record_parser.sv]
// channel   handshake                  content
// s_*       s_tvalid / s_tready        one decoded disk byte, tuser = record start flag
// m_*       m_tvalid / m_tready        one result word, tuser = kind, tlast = record end
// cfg_*     cfg_valid / cfg_ready      register index and data, always ready
//
// one disk byte is taken per cycle while s_tready is high; the parse state, 16-bit crc and counter
// all update in the cycle the byte is accepted
// a result is registered into a two-word skid buffer (main and skid words) before it reaches m_tdata
// s_tready drops only while both buffer words are full, which only a stalled m_tready can cause
// rst_n clears parse state and registers and presets the crc to CRC_INIT; no clearing pass is needed

`include "floppy_sector_record_parser_assert.svh"

module floppy_sector_record_parser
    import fsrp_pkg::*;
#(
    parameter int unsigned MAX_SIZE_CODE = MAX_SIZE_CODE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // disk_byte
    input  logic        s_tuser,   // record_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // payload_byte, log_track, log_side, log_sector,
                                   // size_code, status, zero pad
    output logic [1:0]  m_tuser,   // result_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t cfg;
    res_t res;
    res_t out_res;
    logic res_valid;
    logic accept;

    logic [2:0] m_status;
    logic       out_drain;
    logic       out_data_word;
    logic       out_header_word;
    logic       data_word_ok;
    logic       header_word_ok;

    assign accept = s_tvalid && s_tready;

    fsrp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fsrp_parser #(
        .MAX_SIZE_CODE (MAX_SIZE_CODE)
    ) u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept),
        .record_start (s_tuser),
        .disk_byte    (s_tdata),
        .cfg          (cfg),
        .res_valid    (res_valid),
        .res          (res)
    );

    fsrp_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (s_tready),
        .in_res    (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {2'b00, out_res.status, out_res.size_code, out_res.log_sector,
                      out_res.log_side, out_res.log_track, out_res.payload_byte};
    assign m_tuser = out_res.result_kind;
    assign m_tlast = out_res.last;

    assign m_status        = m_tdata[37:35];
    assign out_drain       = !m_tvalid || m_tready;
    assign out_data_word   = m_tvalid && (m_tuser == KIND_DATA_BYTE);
    assign out_header_word = m_tvalid && (m_tuser == KIND_HEADER);
    assign data_word_ok    = !m_tlast && (m_status == ST_HDR_OK);
    assign header_word_ok  = m_tlast &&
                             (m_status inside {ST_HDR_OK, ST_HDR_CRC_BAD, ST_HDR_IGNORED});

    `FSRP_ASSERT_IMPL(a_stall_needs_full_out, clk, rst_n, !s_tready, m_tvalid)
    `FSRP_ASSERT_NEXT(a_stall_from_backpressure, clk, rst_n, s_tready && out_drain, s_tready)
    `FSRP_ASSERT_IMPL(a_data_byte_not_last, clk, rst_n, out_data_word, data_word_ok)
    `FSRP_ASSERT_IMPL(a_header_status, clk, rst_n, out_header_word, header_word_ok)

endmodule

[verif/testbench.sv]
module testbench;
    import fsrp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef enum logic [2:0] {
        PARSE_IDLE,
        PARSE_SYNC,
        PARSE_MARK,
        PARSE_HEADER,
        PARSE_DATA
    } parse_phase_e;

    localparam int unsigned CRC_NONE = 0;
    localparam int unsigned CRC_GOOD = 1;
    localparam int unsigned CRC_BAD  = 2;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    // parser image kept by the testbench
    cfg_t         cfg_image;
    parse_phase_e phase;
    logic [14:0]  byte_count;
    logic [15:0]  running_crc;
    logic [1:0]   sync_left;
    logic [7:0]   hdr_track;
    logic [7:0]   hdr_side;
    logic [7:0]   hdr_sector;
    logic [2:0]   hdr_size;
    logic         header_accepted;
    logic [7:0]   crc_high;

    res_t         results_due[$];
    logic [7:0]   record_bytes[$];
    int unsigned  bytes_parsed;
    int unsigned  mismatch_count;
    int unsigned  results_seen;
    int unsigned  cycle_count;
    int unsigned  gap_pct;
    int unsigned  stall_pct;

    floppy_sector_record_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results due", cycle_count,
                     results_due.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] c, input logic [7:0] b);
        c = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic void push_result(input logic [1:0] kind, input logic [7:0] payload,
                                        input logic [2:0] st, input logic fin);
        res_t r;
        r.result_kind  = kind;
        r.payload_byte = payload;
        r.log_track    = hdr_track;
        r.log_side     = hdr_side;
        r.log_sector   = hdr_sector;
        r.size_code    = hdr_size;
        r.status       = st;
        r.last         = fin;
        results_due.push_back(r);
    endfunction

    function automatic void take_mark(input logic [7:0] b);
        byte_count = '0;
        if (b == MARK_ID)
            phase = PARSE_HEADER;
        else if (b >= MARK_DATA_LO && b <= MARK_DATA_HI && header_accepted)
            phase = PARSE_DATA;
        else
            phase = PARSE_IDLE;
    endfunction

    // advance the parser image by one accepted disk byte
    task automatic parse_disk_byte(input logic start, input logic [7:0] b);
        int unsigned sector_len;
        logic [2:0]  st;
        if (start || phase != PARSE_IDLE)
            bytes_parsed++;
        if (start)
        begin
            running_crc = crc_ccitt_byte(CRC_INIT, b);
            if (b == SYNC_BYTE)
            begin
                phase = PARSE_SYNC;
                sync_left = 2'd2;
            end
            else
                take_mark(b);
        end
        else
        begin
            case (phase)
                PARSE_SYNC:
                begin
                    running_crc = crc_ccitt_byte(running_crc, b);
                    sync_left = sync_left - 2'd1;
                    if (sync_left == 2'd0)
                        phase = PARSE_MARK;
                end
                PARSE_MARK:
                begin
                    running_crc = crc_ccitt_byte(running_crc, b);
                    take_mark(b);
                end
                PARSE_HEADER:
                begin
                    if (byte_count < 4)
                    begin
                        running_crc = crc_ccitt_byte(running_crc, b);
                        case (byte_count)
                            15'd0: hdr_track = b;
                            15'd1: hdr_side = b;
                            15'd2: hdr_sector = b;
                            default: hdr_size = (b > MAX_SIZE_CODE_DEF) ?
                                                3'(MAX_SIZE_CODE_DEF) : b[2:0];
                        endcase
                        byte_count++;
                    end
                    else if (byte_count == 4)
                    begin
                        crc_high = b;
                        byte_count++;
                    end
                    else
                    begin
                        st = ({crc_high, b} == running_crc) ? ST_HDR_OK : ST_HDR_CRC_BAD;
                        if (cfg_image.side_from_phys)
                            hdr_side = {7'b0, cfg_image.phys_side};
                        hdr_side[0] = hdr_side[0] ^ cfg_image.side_flip;
                        if (cfg_image.track_from_phys)
                            hdr_track = cfg_image.phys_track;
                        if (cfg_image.skip_sector_enable &&
                            hdr_sector == cfg_image.skip_sector_number)
                            st = ST_HDR_IGNORED;
                        header_accepted = (st == ST_HDR_OK);
                        phase = PARSE_IDLE;
                        byte_count = '0;
                        push_result(KIND_HEADER, 8'h00, st, 1'b1);
                    end
                end
                PARSE_DATA:
                begin
                    sector_len = BLOCK_BASE << hdr_size;
                    if (byte_count < sector_len)
                    begin
                        running_crc = crc_ccitt_byte(running_crc, b);
                        byte_count++;
                        push_result(KIND_DATA_BYTE, b, ST_HDR_OK, 1'b0);
                    end
                    else if (byte_count == sector_len)
                    begin
                        crc_high = b;
                        byte_count++;
                    end
                    else
                    begin
                        st = ({crc_high, b} == running_crc) ? ST_DATA_OK : ST_DATA_BAD;
                        header_accepted = 1'b0;
                        phase = PARSE_IDLE;
                        byte_count = '0;
                        push_result(KIND_DATA_STAT, 8'h00, st, 1'b1);
                    end
                end
                default: phase = PARSE_IDLE;
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch %s at result %0d: got 0x%0h want 0x%0h",
                 what, results_seen, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input int unsigned got,
                               input int unsigned want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (results_due.size() == 0)
                report_mismatch("word with nothing due", m_tuser, 0);
            else
            begin
                want = results_due.pop_front();
                check_field("kind", m_tuser, want.result_kind);
                check_field("payload", m_tdata[7:0], want.payload_byte);
                check_field("track", m_tdata[15:8], want.log_track);
                check_field("side", m_tdata[23:16], want.log_side);
                check_field("sector", m_tdata[31:24], want.log_sector);
                check_field("size code", m_tdata[34:32], want.size_code);
                check_field("status", m_tdata[37:35], want.status);
                check_field("pad", m_tdata[39:38], 0);
                check_field("last", m_tlast, want.last);
            end
            results_seen++;
        end
    end

    task automatic send_byte(input logic start, input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        parse_disk_byte(start, b);
    endtask

    task automatic send_record();
        foreach (record_bytes[i])
            send_byte(i == 0, record_bytes[i]);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_PHYS_TRACK:   cfg_image.phys_track = data;
            REG_PHYS_SIDE:    cfg_image.phys_side = data[0];
            REG_IGNORE_TRACK: cfg_image.track_from_phys = data[0];
            REG_IGNORE_SIDE:  cfg_image.side_from_phys = data[0];
            REG_INVERT_SIDE:  cfg_image.side_flip = data[0];
            REG_SKIP_ENABLE:  cfg_image.skip_sector_enable = data[0];
            REG_SKIP_NUMBER:  cfg_image.skip_sector_number = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] track, input logic side, input logic ign_track,
                              input logic ign_side, input logic inv_side,
                              input logic skip_en, input logic [7:0] skip_num);
        // close any open record first
        send_byte(1'b1, 8'h00);
        wait_idle();
        write_reg(REG_PHYS_TRACK, track);
        write_reg(REG_PHYS_SIDE, {7'b0, side});
        write_reg(REG_IGNORE_TRACK, {7'b0, ign_track});
        write_reg(REG_IGNORE_SIDE, {7'b0, ign_side});
        write_reg(REG_INVERT_SIDE, {7'b0, inv_side});
        write_reg(REG_SKIP_ENABLE, {7'b0, skip_en});
        write_reg(REG_SKIP_NUMBER, skip_num);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void begin_record(input bit mfm, input logic [7:0] mark);
        record_bytes.delete();
        if (mfm)
        begin
            record_bytes.push_back(SYNC_BYTE);
            record_bytes.push_back(($urandom_range(9) == 0) ? 8'($urandom) : SYNC_BYTE);
            record_bytes.push_back(($urandom_range(9) == 0) ? 8'($urandom) : SYNC_BYTE);
        end
        record_bytes.push_back(mark);
    endfunction

    function automatic void append_crc(input bit corrupt);
        logic [15:0] c;
        c = CRC_INIT;
        foreach (record_bytes[i])
            c = crc_ccitt_byte(c, record_bytes[i]);
        if (corrupt)
            c = c ^ (16'h1 << $urandom_range(15));
        record_bytes.push_back(c[15:8]);
        record_bytes.push_back(c[7:0]);
    endfunction

    task automatic send_header(input bit mfm, input logic [7:0] track, input logic [7:0] side,
                               input logic [7:0] sector, input logic [7:0] code,
                               input bit corrupt);
        begin_record(mfm, MARK_ID);
        record_bytes.push_back(track);
        record_bytes.push_back(side);
        record_bytes.push_back(sector);
        record_bytes.push_back(code);
        append_crc(corrupt);
        send_record();
    endtask

    task automatic send_data(input bit mfm, input logic [7:0] mark, input int unsigned len,
                             input int unsigned crc_mode);
        begin_record(mfm, mark);
        repeat (len)
            record_bytes.push_back(8'($urandom));
        if (crc_mode != CRC_NONE)
            append_crc(crc_mode == CRC_BAD);
        send_record();
    endtask

    task automatic random_data_record(input bit mfm);
        int unsigned full_len;
        logic [7:0]  mark;
        full_len = BLOCK_BASE << hdr_size;
        mark = MARK_DATA_LO + 8'($urandom_range(3));
        if (!header_accepted)
            send_data(mfm, mark, $urandom_range(1, 4), CRC_NONE);
        else if (full_len <= 256)
            send_data(mfm, mark, full_len, ($urandom_range(4) == 0) ? CRC_BAD : CRC_GOOD);
        else
            send_data(mfm, mark, $urandom_range(1, 16), CRC_NONE);
    endtask

    task automatic test_idle_bytes();
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'hff);
        send_byte(1'b0, SYNC_BYTE);
    endtask

    task automatic test_header_fields();
        set_config(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
        send_header(1'b0, 8'hff, 8'h00, 8'hff, 8'd0, 1'b0);
        send_header(1'b1, 8'h00, 8'hff, 8'h00, 8'd3, 1'b0);
    endtask

    task automatic test_overrides();
        set_config(8'hff, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'hff);
        // ignored sector wins over a bad crc
        send_header(1'b1, 8'h12, 8'h00, 8'hff, 8'd0, 1'b1);
        // size code saturates
        send_header(1'b0, 8'h34, 8'h00, 8'h05, 8'hff, 1'b0);
        set_config(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00);
        send_header(1'b1, 8'h00, 8'hfe, 8'h01, 8'd0, 1'b0);
    endtask

    task automatic test_data_records();
        set_config(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
        // data mark after a failed header is dropped
        send_header(1'b1, 8'h02, 8'h00, 8'h03, 8'd0, 1'b1);
        send_data(1'b1, MARK_DATA_HI, 4, CRC_NONE);
        // sync bytes are not checked
        record_bytes = '{SYNC_BYTE, 8'h00, 8'hff, MARK_ID, 8'h07, 8'h01, 8'h02, 8'h00};
        append_crc(1'b0);
        send_record();
        send_data(1'b1, MARK_DATA_LO, 128, CRC_GOOD);
        // header consumed by the last data record
        send_data(1'b0, 8'hf9, 4, CRC_NONE);
        send_header(1'b0, 8'h08, 8'h01, 8'h04, 8'd0, 1'b0);
        send_data(1'b0, 8'hfa, 128, CRC_BAD);
    endtask

    task automatic test_mark_cases();
        record_bytes = '{SYNC_BYTE, SYNC_BYTE, SYNC_BYTE, 8'h55, 8'h01, 8'h02};
        send_record();
        send_byte(1'b1, 8'hfc);
        send_byte(1'b0, 8'h11);
    endtask

    task automatic test_restart_mid_record();
        begin_record(1'b1, MARK_ID);
        record_bytes.push_back(8'h01);
        record_bytes.push_back(8'h02);
        send_record();
        send_header(1'b1, 8'h09, 8'h00, 8'h02, 8'd0, 1'b0);
        send_data(1'b1, MARK_DATA_LO, 40, CRC_NONE);
        send_header(1'b0, 8'h0a, 8'h01, 8'h03, 8'd1, 1'b0);
        send_data(1'b0, MARK_DATA_HI, 256, CRC_GOOD);
    endtask

    task automatic test_largest_sector();
        // largest size code, record left open and dropped by the next start
        send_header(1'b1, 8'h4f, 8'h01, 8'h09, 8'd7, 1'b0);
        send_data(1'b1, MARK_DATA_HI, 32, CRC_NONE);
    endtask

    task automatic test_random_records(input int unsigned gap, input int unsigned stall,
                                       input int unsigned items);
        int unsigned first;
        int unsigned pick;
        bit          mfm;
        logic [7:0]  mark;
        logic [7:0]  code;
        set_config(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                   1'($urandom), 8'($urandom_range(1, 18)));
        gap_pct = gap;
        stall_pct = stall;
        first = bytes_parsed;
        while (bytes_parsed - first < items)
        begin
            pick = $urandom_range(99);
            mfm = ($urandom_range(9) < 7);
            if (pick < 55)
            begin
                code = ($urandom_range(99) < 75) ? 8'd0 :
                       ($urandom_range(99) < 60) ? 8'd1 :
                       ($urandom_range(1) == 0) ? 8'd2 : 8'($urandom_range(3, 255));
                send_header(mfm, 8'($urandom),
                            ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1)),
                            ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 18)),
                            code, $urandom_range(9) == 0);
                if ($urandom_range(9) < 7)
                    random_data_record(mfm);
            end
            else if (pick < 70)
                random_data_record(mfm);
            else if (pick < 80)
            begin
                mark = 8'($urandom);
                if ($urandom_range(1) == 0)
                    mark = MARK_ID;
                else if (mark == MARK_ID || (mark >= MARK_DATA_LO && mark <= MARK_DATA_HI))
                    mark = 8'h00;
                begin_record(mfm, mark);
                repeat ($urandom_range(0, 4))
                    record_bytes.push_back(8'($urandom));
                send_record();
            end
            else
            begin
                repeat ($urandom_range(1, 12))
                    send_byte($urandom_range(7) == 0, 8'($urandom));
            end
        end
        gap_pct = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = 8'h00;
        m_tready = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = REG_PHYS_TRACK;
        cfg_data = 8'h00;
        gap_pct = 0;
        stall_pct = 0;
        mismatch_count = 0;
        results_seen = 0;
        cycle_count = 0;
        bytes_parsed = 0;
        cfg_image = '0;
        phase = PARSE_IDLE;
        byte_count = '0;
        running_crc = CRC_INIT;
        sync_left = 2'd0;
        hdr_track = 8'h00;
        hdr_side = 8'h00;
        hdr_sector = 8'h00;
        hdr_size = 3'd0;
        header_accepted = 1'b0;
        crc_high = 8'h00;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_bytes();
        test_header_fields();
        test_overrides();
        test_data_records();
        test_mark_cases();
        test_restart_mid_record();
        test_largest_sector();
        test_random_records(0, 0, 40);
        test_random_records(50, 0, 40);
        test_random_records(0, 50, 40);
        test_random_records(12, 12, 40);

        wait_idle();
        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
